FILE: hw/rtl/hvscp_pkg.sv
// types and constants for the high-voltage serial command parser
package hvscp_pkg;

   localparam int unsigned ACC_W = 24;
   localparam logic [ACC_W-1:0] ACC_MAX = 24'hFFFFFF;
   // largest accumulator that can still be multiplied by ten without saturating
   localparam logic [ACC_W-1:0] ACC_MUL_LIMIT = ACC_MAX / 10;

   localparam logic [7:0] STOP_BYTE = 8'h0D;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_LF    = 8'h0A;
   localparam logic [7:0] CHR_VT    = 8'h0B;
   localparam logic [7:0] CHR_FF    = 8'h0C;
   localparam logic [7:0] CHR_QUERY = 8'h3F;
   localparam logic [7:0] CHR_MINUS = 8'h2D;
   localparam logic [7:0] CHR_PLUS  = 8'h2B;
   localparam logic [7:0] CHR_POINT = 8'h2E;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_NINE  = 8'h39;
   localparam logic [7:0] CHR_ONE   = 8'h31;
   localparam logic [7:0] CHR_TWO   = 8'h32;

   localparam logic [15:0] CMD_POWER   = 16'h504F;
   localparam logic [15:0] CMD_VOLTAGE = 16'h5356;
   localparam logic [15:0] CMD_CURRENT = 16'h5349;
   localparam logic [15:0] CMD_ERROR   = 16'h4545;

   localparam logic [15:0] VOLTAGE_LIMIT_RESET = 16'd2400;
   localparam logic [23:0] CURRENT_LIMIT_RESET = 24'd50000;

   typedef enum logic [0:0] {
      CSR_VOLTAGE_LIMIT = 1'b0,
      CSR_CURRENT_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_POWER   = 3'd0,
      OP_VOLTAGE = 3'd1,
      OP_CURRENT = 3'd2,
      OP_READ_ERROR = 3'd3,
      OP_UNKNOWN = 3'd4
   } operation_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_SOURCE   = 3'd1,
      ERR_COMMAND  = 3'd2,
      ERR_VOLTAGE  = 3'd3,
      ERR_CURRENT  = 3'd4
   } error_type;

   typedef enum logic [5:0] {
      PH_SOURCE      = 6'b000001,
      PH_LETTER_HI   = 6'b000010,
      PH_LETTER_LO   = 6'b000100,
      PH_VALUE_START = 6'b001000,
      PH_VALUE_BODY  = 6'b010000,
      PH_SKIP        = 6'b100000
   } phase_type;

endpackage

FILE: hw/rtl/hv_serial_command_parser.sv
// high-voltage supply serial command parser, one received byte per item
// latency: the result of a stop byte is on rsp_ the cycle after that byte is accepted
// throughput: one byte per cycle while req_ready is high; the parse state updates in the cycle of acceptance
// one result register: req_ready stays high while the held result is being taken
// reset (synchronous, active high) returns to waiting for a source byte, clears
// the parse state, empties the result register and reloads both limits
module hv_serial_command_parser
   import hvscp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   // decoded command output
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_channel,
   output logic [2:0]  rsp_operation,
   output logic [15:0] rsp_command_letters,
   output logic [23:0] rsp_amount_hundredths,
   output logic        rsp_is_query,
   output logic [2:0]  rsp_error_code,
   // limit registers
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [23:0] csr_write_data
);

   // limits; the voltage limit is kept scaled to hundredths so no divide is needed
   logic [15:0]      voltage_limit_ff;
   logic [22:0]      voltage_limit_x100_ff;
   logic [23:0]      current_limit_ff;

   // parse state
   phase_type        phase_ff, phase_in;
   logic [1:0]       channel_ff, channel_in;
   logic [15:0]      letters_ff, letters_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [1:0]       frac_ff, frac_in;
   logic             point_ff, point_in;
   logic             query_ff, query_in;
   logic             ended_ff, ended_in;

   // result register
   logic             rsp_valid_ff;
   logic [1:0]       rsp_channel_ff;
   operation_type    rsp_operation_ff;
   logic [15:0]      rsp_letters_ff;
   logic [ACC_W-1:0] rsp_amount_ff;
   logic             rsp_query_ff;
   error_type        rsp_error_ff;

   logic             accept;
   logic             emit;
   logic [7:0]       rx;
   logic             is_digit;
   logic [3:0]       digit;
   logic             is_space;

   // value byte datapath
   logic [27:0]      acc_times10;
   logic [27:0]      int_sum;
   logic [ACC_W:0]   tenth_sum;
   logic [ACC_W:0]   hundredth_sum;
   logic [ACC_W-1:0] int_acc;
   logic [ACC_W-1:0] tenth_acc;
   logic [ACC_W-1:0] hundredth_acc;

   // command decode of the held letters
   operation_type    op_dec;
   error_type        err_dec;

   // output register frees up when empty or being taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rx        = req_rx_byte;

   assign is_digit = (rx >= CHR_ZERO) && (rx <= CHR_NINE);
   assign digit    = rx[3:0];
   assign is_space = (rx == CHR_SPACE) || (rx == CHR_TAB) || (rx == CHR_LF)
                     || (rx == CHR_VT) || (rx == CHR_FF);

   // integer digit: acc*10 (saturated first) + d*100, then saturate
   always_comb begin
      acc_times10 = (acc_ff > ACC_MUL_LIMIT) ? {4'd0, ACC_MAX}
                    : ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1);
      int_sum     = acc_times10 + ({24'd0, digit} * 28'd100);
      int_acc     = (int_sum > {4'd0, ACC_MAX}) ? ACC_MAX : int_sum[ACC_W-1:0];
      tenth_sum   = {1'b0, acc_ff} + ({21'd0, digit} * 25'd10);
      tenth_acc   = tenth_sum[ACC_W] ? ACC_MAX : tenth_sum[ACC_W-1:0];
      hundredth_sum = {1'b0, acc_ff} + (ACC_W+1)'(digit);
      hundredth_acc = hundredth_sum[ACC_W] ? ACC_MAX : hundredth_sum[ACC_W-1:0];
   end

   // decode and error priority from the held fields
   always_comb begin
      case (letters_ff)
         CMD_POWER:   op_dec = OP_POWER;
         CMD_VOLTAGE: op_dec = OP_VOLTAGE;
         CMD_CURRENT: op_dec = OP_CURRENT;
         CMD_ERROR:   op_dec = OP_READ_ERROR;
         default:     op_dec = OP_UNKNOWN;
      endcase
      if (channel_ff == 2'd0) begin
         err_dec = ERR_SOURCE;
      end else if (op_dec == OP_UNKNOWN) begin
         err_dec = ERR_COMMAND;
      end else if (op_dec == OP_VOLTAGE && !query_ff
                   && acc_ff >= {1'b0, voltage_limit_x100_ff}) begin
         err_dec = ERR_VOLTAGE;
      end else if (op_dec == OP_CURRENT && !query_ff && acc_ff >= current_limit_ff) begin
         err_dec = ERR_CURRENT;
      end else begin
         err_dec = ERR_NONE;
      end
   end

   // next parse state
   always_comb begin
      phase_in   = phase_ff;
      channel_in = channel_ff;
      letters_in = letters_ff;
      acc_in     = acc_ff;
      frac_in    = frac_ff;
      point_in   = point_ff;
      query_in   = query_ff;
      ended_in   = ended_ff;
      emit       = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_LETTER_HI: begin
               letters_in = {rx, 8'h00};
               phase_in   = PH_LETTER_LO;
            end
            PH_LETTER_LO: begin
               letters_in = {letters_ff[15:8], rx};
               acc_in     = '0;
               frac_in    = 2'd0;
               point_in   = 1'b0;
               query_in   = 1'b0;
               ended_in   = 1'b0;
               phase_in   = PH_VALUE_START;
            end
            PH_VALUE_START, PH_VALUE_BODY, PH_SKIP: begin
               if (rx == STOP_BYTE) begin
                  emit     = 1'b1;
                  phase_in = PH_SOURCE;
               end else if (phase_ff == PH_SKIP) begin
                  phase_in = PH_SKIP;
               end else if (phase_ff == PH_VALUE_START && is_space) begin
                  phase_in = PH_VALUE_START;
               end else if (phase_ff == PH_VALUE_START && rx == CHR_QUERY) begin
                  query_in = 1'b1;
                  phase_in = PH_SKIP;
               end else if (phase_ff == PH_VALUE_START && rx == CHR_MINUS) begin
                  query_in = 1'b1;
                  phase_in = PH_VALUE_BODY;
               end else if (phase_ff == PH_VALUE_START && rx == CHR_PLUS) begin
                  phase_in = PH_VALUE_BODY;
               end else begin
                  // value byte, first of the body or later
                  phase_in = PH_VALUE_BODY;
                  if (!ended_ff) begin
                     if (is_digit) begin
                        if (!point_ff) begin
                           acc_in = int_acc;
                        end else if (frac_ff == 2'd0) begin
                           acc_in  = tenth_acc;
                           frac_in = 2'd1;
                        end else if (frac_ff == 2'd1) begin
                           acc_in  = hundredth_acc;
                           frac_in = 2'd2;
                        end
                     end else if (rx == CHR_POINT && !point_ff) begin
                        point_in = 1'b1;
                     end else begin
                        ended_in = 1'b1;
                     end
                  end
               end
            end
            default: begin
               // source byte
               channel_in = (rx == CHR_ONE) ? 2'd1 : (rx == CHR_TWO) ? 2'd2 : 2'd0;
               phase_in   = PH_LETTER_HI;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SOURCE;
         channel_ff <= 2'd0;
         letters_ff <= 16'd0;
         acc_ff     <= '0;
         frac_ff    <= 2'd0;
         point_ff   <= 1'b0;
         query_ff   <= 1'b0;
         ended_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         channel_ff <= channel_in;
         letters_ff <= letters_in;
         acc_ff     <= acc_in;
         frac_ff    <= frac_in;
         point_ff   <= point_in;
         query_ff   <= query_in;
         ended_ff   <= ended_in;
      end
   end

   // limit registers; the scaled copy is formed at write time
   always_ff @(posedge clock) begin
      if (reset) begin
         voltage_limit_ff      <= VOLTAGE_LIMIT_RESET;
         voltage_limit_x100_ff <= {7'd0, VOLTAGE_LIMIT_RESET} * 23'd100;
         current_limit_ff      <= CURRENT_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_VOLTAGE_LIMIT: begin
               voltage_limit_ff      <= csr_write_data[15:0];
               voltage_limit_x100_ff <= {7'd0, csr_write_data[15:0]} * 23'd100;
            end
            CSR_CURRENT_LIMIT: current_limit_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_channel_ff   <= channel_ff;
         rsp_operation_ff <= op_dec;
         rsp_letters_ff   <= letters_ff;
         rsp_amount_ff    <= acc_ff;
         rsp_query_ff     <= query_ff;
         rsp_error_ff     <= err_dec;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_channel           = rsp_channel_ff;
   assign rsp_operation         = rsp_operation_ff;
   assign rsp_command_letters   = rsp_letters_ff;
   assign rsp_amount_hundredths = rsp_amount_ff;
   assign rsp_is_query          = rsp_query_ff;
   assign rsp_error_code        = rsp_error_ff;

   // scaled voltage limit always tracks the written limit
   a_vlimit_scaled: assert property (@(posedge clock) disable iff (reset)
      voltage_limit_x100_ff == ({7'd0, voltage_limit_ff} * 23'd100))
      else $error("scaled voltage limit out of step");

   // a new result only follows an accepted stop byte in a value phase
   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_ready)) |->
      ($past(accept) && $past(rx) == STOP_BYTE)
      && ($past(phase_ff) == PH_VALUE_START || $past(phase_ff) == PH_VALUE_BODY
          || $past(phase_ff) == PH_SKIP))
      else $error("result without a stop byte");

   // fraction digits are counted only after a point
   a_frac_point: assert property (@(posedge clock) disable iff (reset)
      (frac_ff != 2'd0) |-> point_ff)
      else $error("fraction digits without point");

   // bad source code exactly when channel is zero
   a_source_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_channel_ff == 2'd0) == (rsp_error_ff == ERR_SOURCE)))
      else $error("source error does not match channel");

   // a query answer never reports a limit error
   a_query_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_query_ff) |->
      (rsp_error_ff != ERR_VOLTAGE && rsp_error_ff != ERR_CURRENT))
      else $error("limit error on a query");

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the serial command parser: directed commands, then random traffic
`timescale 1ns / 100ps

module tb_top
   import hvscp_pkg::*;
();

   // one decoded command as it leaves the block
   typedef struct packed {
      logic [1:0]    channel;
      operation_type operation;
      logic [15:0]   command_letters;
      logic [23:0]   amount_hundredths;
      logic          is_query;
      error_type     error_code;
   } decoded_cmd_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_channel;
   logic [2:0]  rsp_operation;
   logic [15:0] rsp_command_letters;
   logic [23:0] rsp_amount_hundredths;
   logic        rsp_is_query;
   logic [2:0]  rsp_error_code;
   logic        csr_write_enable;
   logic [0:0]  csr_index;
   logic [23:0] csr_write_data;

   hv_serial_command_parser uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_rx_byte           (req_rx_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_channel           (rsp_channel),
      .rsp_operation         (rsp_operation),
      .rsp_command_letters   (rsp_command_letters),
      .rsp_amount_hundredths (rsp_amount_hundredths),
      .rsp_is_query          (rsp_is_query),
      .rsp_error_code        (rsp_error_code),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   // parser state mirrored by the predictor
   phase_type   parse_phase;
   logic [1:0]  src_channel;
   logic [15:0] cmd_letters;
   logic [23:0] value_cents;
   logic [1:0]  frac_count;
   logic        saw_point;
   logic        query_seen;
   logic        value_done;

   // limit registers as last written
   logic [15:0] volt_limit;
   logic [23:0] amp_limit_cents;

   // commands predicted but not yet seen on rsp_
   decoded_cmd_type pending_commands[$];

   // directed table: command text, whether the result is typed in, and that result
   string           row_text[$];
   bit              row_typed[$];
   decoded_cmd_type row_expect[$];

   int mismatch_count = 0;
   int bytes_sent = 0;
   bit sender_quick = 1'b0;
   bit receiver_quick = 1'b0;
   bit hold_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // runaway guard
   initial begin : watchdog
      #3_000_000;
      $display("Mismatches found");
      $finish;
   end

   // advance the parser by one byte; returns 1 when a command completes
   function automatic bit parse_byte(input logic [7:0] b, output decoded_cmd_type cmd);
      logic [31:0]   sum;
      logic [31:0]   digit;
      operation_type op;
      error_type     err;
      bit            take;
      bit            produced;
      produced = 1'b0;
      take = 1'b0;
      cmd = '0;
      case (parse_phase)
         PH_LETTER_HI: begin
            cmd_letters = {b, 8'h00};
            parse_phase = PH_LETTER_LO;
         end
         PH_LETTER_LO: begin
            cmd_letters[7:0] = b;
            value_cents = '0;
            frac_count = '0;
            saw_point = 1'b0;
            query_seen = 1'b0;
            value_done = 1'b0;
            parse_phase = PH_VALUE_START;
         end
         PH_VALUE_START, PH_VALUE_BODY, PH_SKIP: begin
            if (b == STOP_BYTE) begin
               case (cmd_letters)
                  CMD_POWER:   op = OP_POWER;
                  CMD_VOLTAGE: op = OP_VOLTAGE;
                  CMD_CURRENT: op = OP_CURRENT;
                  CMD_ERROR:   op = OP_READ_ERROR;
                  default:     op = OP_UNKNOWN;
               endcase
               // bad source wins, then unknown letters, then the limits on plain sets
               if (src_channel == 2'd0)
                  err = ERR_SOURCE;
               else if (op == OP_UNKNOWN)
                  err = ERR_COMMAND;
               else if (op == OP_VOLTAGE && !query_seen
                        && (value_cents / 24'd100) >= {8'h00, volt_limit})
                  err = ERR_VOLTAGE;
               else if (op == OP_CURRENT && !query_seen && value_cents >= amp_limit_cents)
                  err = ERR_CURRENT;
               else
                  err = ERR_NONE;
               cmd = {src_channel, op, cmd_letters, value_cents, query_seen, err};
               produced = 1'b1;
               parse_phase = PH_SOURCE;
            end else if (parse_phase == PH_VALUE_START) begin
               if (b == CHR_SPACE || b == CHR_TAB || b == CHR_LF
                   || b == CHR_VT || b == CHR_FF) begin
                  // leading white space is dropped
               end else if (b == CHR_QUERY) begin
                  query_seen = 1'b1;
                  parse_phase = PH_SKIP;
               end else begin
                  parse_phase = PH_VALUE_BODY;
                  if (b == CHR_MINUS)
                     query_seen = 1'b1;
                  else if (b != CHR_PLUS)
                     take = 1'b1;
               end
            end else if (parse_phase == PH_VALUE_BODY) begin
               take = 1'b1;
            end
         end
         default: begin
            src_channel = (b == CHR_ONE) ? 2'd1 : (b == CHR_TWO) ? 2'd2 : 2'd0;
            parse_phase = PH_LETTER_HI;
         end
      endcase

      // digits accumulate in hundredths, saturating
      if (take && !value_done) begin
         if (b >= CHR_ZERO && b <= CHR_NINE) begin
            digit = 32'(b - CHR_ZERO);
            if (!saw_point) begin
               sum = (value_cents > ACC_MUL_LIMIT) ? 32'(ACC_MAX) : 32'(value_cents) * 10;
               sum = sum + digit * 100;
            end else if (frac_count == 2'd0) begin
               sum = 32'(value_cents) + digit * 10;
               frac_count = 2'd1;
            end else if (frac_count == 2'd1) begin
               sum = 32'(value_cents) + digit;
               frac_count = 2'd2;
            end else begin
               // digits past the second decimal are dropped
               sum = 32'(value_cents);
            end
            value_cents = (sum > 32'(ACC_MAX)) ? ACC_MAX : sum[23:0];
         end else if (b == CHR_POINT && !saw_point) begin
            saw_point = 1'b1;
         end else begin
            value_done = 1'b1;
         end
      end
      return produced;
   endfunction

   // offer one byte, wait for acceptance, then queue what it completes
   task automatic send_byte(input logic [7:0] b, input bit use_typed,
                            input decoded_cmd_type typed);
      int              gap;
      decoded_cmd_type predicted;
      gap = sender_quick ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (parse_byte(b, predicted))
         pending_commands.push_back(use_typed ? typed : predicted);
   endtask

   // sender pause: stop offering until every queued command has come back
   task automatic drain_pending();
      req_valid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
   endtask

   task automatic add_typed_row(input string text, input logic [1:0] ch, input operation_type op,
                                input logic [15:0] letters, input logic [23:0] amount,
                                input logic query, input error_type err);
      row_text.push_back(text);
      row_typed.push_back(1'b1);
      row_expect.push_back({ch, op, letters, amount, query, err});
   endtask

   task automatic add_checked_row(input string text);
      row_text.push_back(text);
      row_typed.push_back(1'b0);
      row_expect.push_back('0);
   endtask

   // one mostly well-formed command with random content
   task automatic send_random_command();
      string       text;
      int          pick;
      int          n;
      logic [15:0] letters;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         text = $sformatf("%c", $urandom_range(1, 255));
      else
         text = $sformatf("%c", (pick < 5) ? CHR_ONE : CHR_TWO);
      case ($urandom_range(0, 9))
         0:       letters = CMD_POWER;
         1:       letters = CMD_ERROR;
         2, 3, 4: letters = CMD_VOLTAGE;
         5, 6, 7: letters = CMD_CURRENT;
         8:       letters = {CMD_VOLTAGE[15:8], 8'($urandom_range(1, 255))};
         default: letters = {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
      endcase
      text = {text, $sformatf("%c%c", letters[15:8], letters[7:0])};
      // white space ahead of the value
      case ($urandom_range(0, 5))
         0:       text = {text, " "};
         1:       text = {text, "\t"};
         2:       text = {text, "\n"};
         3:       text = {text, "\013\014 "};
         default: ;
      endcase
      // sign or query
      case ($urandom_range(0, 9))
         0:       text = {text, "-"};
         1:       text = {text, "+"};
         2:       text = {text, "?"};
         default: ;
      endcase
      case ($urandom_range(0, 9))
         0: begin
            // around the voltage limit
            n = int'(volt_limit) + int'($urandom_range(0, 2)) - 1;
            if (n < 0)
               n = 0;
            text = {text, $sformatf("%0d", n)};
            if ($urandom_range(0, 1) == 1)
               text = {text, $sformatf(".%0d", $urandom_range(0, 99))};
         end
         1: begin
            // around the current limit, in hundredths
            n = int'(amp_limit_cents) + int'($urandom_range(0, 2)) - 1;
            if (n < 0)
               n = 0;
            text = {text, $sformatf("%0d.%02d", n / 100, n % 100)};
         end
         2:       text = {text, $sformatf("%0d%09d", $urandom_range(1, 99999),
                                          $urandom_range(0, 999999999))};
         3:       ;
         4:       text = {text, $sformatf(".%0d", $urandom_range(0, 999))};
         default: begin
            text = {text, $sformatf("%0d", $urandom_range(0, 3000))};
            case ($urandom_range(0, 4))
               0:       text = {text, "."};
               1:       text = {text, $sformatf(".%0d", $urandom_range(0, 9))};
               2:       text = {text, $sformatf(".%02d", $urandom_range(0, 99))};
               3:       text = {text, $sformatf(".%03d", $urandom_range(0, 999))};
               default: ;
            endcase
         end
      endcase
      // trailing junk that ends the digits
      case ($urandom_range(0, 9))
         0:       text = {text, "x7"};
         1:       text = {text, ".."};
         2:       text = {text, $sformatf("%c", $urandom_range(1, 255))};
         default: ;
      endcase
      text = {text, "\r"};
      if ($urandom_range(0, 9) == 0)
         sender_quick = !sender_quick;
      for (int i = 0; i < text.len(); i++)
         send_byte(text[i], 1'b0, '0);
   endtask

   // result side: random stalls, one long hold on request, compare in order
   initial begin : result_checker
      int              stall;
      decoded_cmd_type want;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            // long hold so the result register fills and req_ready drops
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            if ($urandom_range(0, 9) == 0)
               receiver_quick = !receiver_quick;
            stall = receiver_quick ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_commands.size() == 0) begin
            $error("result with no command pending: letters %h", rsp_command_letters);
            mismatch_count++;
         end else begin
            want = pending_commands.pop_front();
            if (rsp_channel !== want.channel) begin
               $error("channel: expected %0d, actual %0d", want.channel, rsp_channel);
               mismatch_count++;
            end
            if (rsp_operation !== want.operation) begin
               $error("operation: expected %0d, actual %0d", want.operation, rsp_operation);
               mismatch_count++;
            end
            if (rsp_command_letters !== want.command_letters) begin
               $error("command_letters: expected %h, actual %h", want.command_letters,
                      rsp_command_letters);
               mismatch_count++;
            end
            if (rsp_amount_hundredths !== want.amount_hundredths) begin
               $error("amount_hundredths: expected %0d, actual %0d", want.amount_hundredths,
                      rsp_amount_hundredths);
               mismatch_count++;
            end
            if (rsp_is_query !== want.is_query) begin
               $error("is_query: expected %0d, actual %0d", want.is_query, rsp_is_query);
               mismatch_count++;
            end
            if (rsp_error_code !== want.error_code) begin
               $error("error_code: expected %0d, actual %0d", want.error_code, rsp_error_code);
               mismatch_count++;
            end
         end
      end
   end

   // stimulus
   initial begin : byte_source
      string row;
      int    stop_at;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= 8'h00;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_VOLTAGE_LIMIT;
      csr_write_data <= '0;
      parse_phase = PH_SOURCE;
      src_channel = '0;
      cmd_letters = '0;
      value_cents = '0;
      frac_count = '0;
      saw_point = 1'b0;
      query_seen = 1'b0;
      value_done = 1'b0;
      volt_limit = VOLTAGE_LIMIT_RESET;
      amp_limit_cents = CURRENT_LIMIT_RESET;

      // directed commands, run with the limits at their reset values
      add_typed_row("1PO\r", 2'd1, OP_POWER, CMD_POWER, 24'd0, 1'b0, ERR_NONE);
      add_typed_row("9XY\r", 2'd0, OP_UNKNOWN, 16'h5859, 24'd0, 1'b0, ERR_SOURCE);
      // stop bytes in the source and letter slots are taken as those fields
      add_typed_row("\r\r\r\r", 2'd0, OP_UNKNOWN, 16'h0D0D, 24'd0, 1'b0, ERR_SOURCE);
      add_typed_row("2AB\r", 2'd2, OP_UNKNOWN, 16'h4142, 24'd0, 1'b0, ERR_COMMAND);
      add_typed_row("2EE\r", 2'd2, OP_READ_ERROR, CMD_ERROR, 24'd0, 1'b0, ERR_NONE);
      // digits after a query mark are skipped
      add_typed_row("2SV?7\r", 2'd2, OP_VOLTAGE, CMD_VOLTAGE, 24'd0, 1'b1, ERR_NONE);
      add_typed_row("1SV2400\r", 2'd1, OP_VOLTAGE, CMD_VOLTAGE, 24'd240000, 1'b0, ERR_VOLTAGE);
      add_checked_row("1SV2399.999\r");
      add_typed_row("1SI500\r", 2'd1, OP_CURRENT, CMD_CURRENT, 24'd50000, 1'b0, ERR_CURRENT);
      add_checked_row("2SI \t\n\013\014-499.999\r");
      // accumulator saturation
      add_typed_row("1SV+99999999999\r", 2'd1, OP_VOLTAGE, CMD_VOLTAGE, ACC_MAX, 1'b0,
                    ERR_VOLTAGE);
      add_checked_row("1SV1.2.3\r");
      add_checked_row("2PO-x5\r");
      // all-ones bytes in the source and low letter slots
      add_typed_row("\3772\377\377\r", 2'd0, OP_UNKNOWN, 16'h32FF, 24'd0, 1'b0, ERR_SOURCE);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < row_text.size(); r++) begin
         row = row_text[r];
         for (int i = 0; i < row.len(); i++)
            send_byte(row[i], row_typed[r] && (i == row.len() - 1), row_expect[r]);
      end

      // random phases, each under its own pair of limits
      for (int p = 0; p < 5; p++) begin
         drain_pending();
         repeat (4) @(posedge clock);
         case (p)
            0: begin
               volt_limit = '0;
               amp_limit_cents = '0;
            end
            1: begin
               volt_limit = 16'hFFFF;
               amp_limit_cents = ACC_MAX;
            end
            2: begin
               volt_limit = VOLTAGE_LIMIT_RESET;
               amp_limit_cents = CURRENT_LIMIT_RESET;
            end
            default: begin
               volt_limit = 16'($urandom_range(0, 3000));
               amp_limit_cents = 24'($urandom_range(0, 400000));
            end
         endcase
         csr_write_enable <= 1'b1;
         csr_index <= CSR_VOLTAGE_LIMIT;
         csr_write_data <= {8'h00, volt_limit};
         @(posedge clock);
         csr_index <= CSR_CURRENT_LIMIT;
         csr_write_data <= amp_limit_cents;
         @(posedge clock);
         csr_write_enable <= 1'b0;

         // one phase runs into a long result-side hold while bytes keep coming
         if (p == 2)
            hold_request = 1'b1;

         stop_at = bytes_sent + 112;
         while (bytes_sent < stop_at) begin
            // occasional raw noise, which also breaks command framing
            if ($urandom_range(0, 7) == 0)
               repeat ($urandom_range(1, 5))
                  send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            send_random_command();
         end
      end

      drain_pending();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
